[src/oebp_pkg.sv]
// shared constants, types and helpers of the order entry body parser
package oebp_pkg;

  localparam int MaxFirm  = 256;
  localparam int FixedLen = 36;
  localparam int WinLen   = 8;
  localparam int OffW     = $clog2(FixedLen);
  localparam int FillW    = $clog2(WinLen + 1);
  localparam int WinIdxW  = $clog2(WinLen);
  localparam int FcntW    = $clog2(MaxFirm + 1);

  localparam logic [7:0] CharD = 8'h44;
  localparam logic [7:0] CharB = 8'h42;

  // body offsets where each field starts
  localparam logic [OffW-1:0] OffQty    = OffW'(8);
  localparam logic [OffW-1:0] OffIhead  = OffW'(12);
  localparam logic [OffW-1:0] OffItail  = OffW'(14);
  localparam logic [OffW-1:0] OffSide   = OffW'(22);
  localparam logic [OffW-1:0] OffClient = OffW'(23);
  localparam logic [OffW-1:0] OffTif    = OffW'(31);
  localparam logic [OffW-1:0] OffTag    = OffW'(32);
  localparam logic [OffW-1:0] OffFirmId = OffW'(FixedLen - 1);

  typedef enum logic [2:0] {
    KindRecord = 3'd0,
    KindFirm   = 3'd1,
    KindTerm   = 3'd2,
    KindStream = 3'd3,
    KindOver   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [63:0]  price;
    logic [31:0]  quantity;
    logic [15:0]  instrument_head;
    logic [63:0]  instrument_tail;
    logic [7:0]   side;
    logic [63:0]  client_ref;
    logic [7:0]   tif_code;
    logic [23:0]  tag_chars;
    logic [7:0]   firm_id;
    logic [7:0]   firm_byte;
    logic         last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic result_t blank_result(kind_e k);
    result_t r;
    r      = '0;
    r.kind = k;
    return r;
  endfunction

  // terminator pattern: D at even places, B at odd places
  function automatic logic [7:0] term_char(int unsigned i);
    return i[0] ? CharB : CharD;
  endfunction

endpackage

[src/oebp_in_if.sv]
// input byte channel
interface oebp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

[src/oebp_out_if.sv]
// result channel
interface oebp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] price;
  logic [31:0] quantity;
  logic [15:0] instrument_head;
  logic [63:0] instrument_tail;
  logic [7:0]  side;
  logic [63:0] client_ref;
  logic [7:0]  tif_code;
  logic [23:0] tag_chars;
  logic [7:0]  firm_id;
  logic [7:0]  firm_byte;
  logic        last;

  modport source (
    output valid, output kind, output price, output quantity, output instrument_head,
    output instrument_tail, output side, output client_ref, output tif_code,
    output tag_chars, output firm_id, output firm_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input price, input quantity, input instrument_head,
    input instrument_tail, input side, input client_ref, input tif_code,
    input tag_chars, input firm_id, input firm_byte, input last, output ready
  );
endinterface

[src/oebp_core.sv]
// parse state and per-byte decode: fixed fields, firm window, end detection
module oebp_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 stream_end_i,
  output oebp_pkg::push_t      push_o
);

  logic [oebp_pkg::OffW-1:0]  offset_q, offset_d;
  logic                       firm_q, firm_d;
  logic [63:0]                price_q, price_d;
  logic [31:0]                qty_q, qty_d;
  logic [15:0]                ihead_q, ihead_d;
  logic [63:0]                itail_q, itail_d;
  logic [7:0]                 side_q, side_d;
  logic [63:0]                client_q, client_d;
  logic [7:0]                 tif_q, tif_d;
  logic [23:0]                tag_q, tag_d;
  logic [7:0]                 win_q [oebp_pkg::WinLen];
  logic [7:0]                 win_d [oebp_pkg::WinLen];
  logic [oebp_pkg::FillW-1:0] fill_q, fill_d;
  logic [oebp_pkg::FcntW-1:0] fcount_q, fcount_d;
  logic                       over_q, over_d;

  oebp_pkg::result_t res0, res1;
  logic [1:0]        cnt;
  logic              term;
  logic              clear;
  logic [2:0]        cidx;
  oebp_pkg::kind_e   end_kind;

  assign cidx = 3'(offset_q - oebp_pkg::OffClient);

  always_comb begin
    offset_d = offset_q;
    firm_d   = firm_q;
    price_d  = price_q;
    qty_d    = qty_q;
    ihead_d  = ihead_q;
    itail_d  = itail_q;
    side_d   = side_q;
    client_d = client_q;
    tif_d    = tif_q;
    tag_d    = tag_q;
    win_d    = win_q;
    fill_d   = fill_q;
    fcount_d = fcount_q;
    over_d   = over_q;
    res0     = oebp_pkg::blank_result(oebp_pkg::KindRecord);
    res1     = oebp_pkg::blank_result(oebp_pkg::KindRecord);
    cnt      = 2'd0;
    term     = 1'b0;
    clear    = 1'b0;
    end_kind = oebp_pkg::KindTerm;

    if (stream_end_i) begin
      res0  = oebp_pkg::blank_result(oebp_pkg::KindStream);
      cnt   = 2'd1;
      clear = 1'b1;
    end else if (firm_q) begin
      if (fill_q == oebp_pkg::FillW'(oebp_pkg::WinLen)) begin
        for (int i = 0; i < oebp_pkg::WinLen - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[oebp_pkg::WinLen-1] = data_byte_i;
        if (fcount_q >= oebp_pkg::FcntW'(oebp_pkg::MaxFirm)) begin
          over_d = 1'b1;
        end else begin
          fcount_d       = fcount_q + 1'b1;
          res0           = oebp_pkg::blank_result(oebp_pkg::KindFirm);
          res0.firm_byte = win_q[0];
          cnt            = 2'd1;
        end
      end else begin
        win_d[fill_q[oebp_pkg::WinIdxW-1:0]] = data_byte_i;
        fill_d = fill_q + 1'b1;
      end

      term = (fill_d == oebp_pkg::FillW'(oebp_pkg::WinLen));
      for (int unsigned i = 0; i < oebp_pkg::WinLen; i++) begin
        if (win_d[i] != oebp_pkg::term_char(i)) term = 1'b0;
      end

      if (term) begin
        end_kind = over_d ? oebp_pkg::KindOver : oebp_pkg::KindTerm;
        if (cnt == 2'd1) begin
          res1 = oebp_pkg::blank_result(end_kind);
        end else begin
          res0 = oebp_pkg::blank_result(end_kind);
        end
        cnt   = cnt + 2'd1;
        clear = 1'b1;
      end
    end else begin
      if (offset_q < oebp_pkg::OffQty) begin
        price_d[8*offset_q[2:0] +: 8] = data_byte_i;
      end else if (offset_q < oebp_pkg::OffIhead) begin
        qty_d[8*offset_q[1:0] +: 8] = data_byte_i;
      end else if (offset_q < oebp_pkg::OffItail) begin
        ihead_d = {ihead_q[7:0], data_byte_i};
      end else if (offset_q < oebp_pkg::OffSide) begin
        itail_d = {itail_q[55:0], data_byte_i};
      end else if (offset_q == oebp_pkg::OffSide) begin
        side_d = data_byte_i;
      end else if (offset_q < oebp_pkg::OffTif) begin
        client_d[8*cidx +: 8] = data_byte_i;
      end else if (offset_q == oebp_pkg::OffTif) begin
        tif_d = data_byte_i;
      end else if (offset_q < oebp_pkg::OffFirmId) begin
        tag_d = {tag_q[15:0], data_byte_i};
      end

      if (offset_q == oebp_pkg::OffFirmId) begin
        res0                 = oebp_pkg::blank_result(oebp_pkg::KindRecord);
        res0.price           = price_q;
        res0.quantity        = qty_q;
        res0.instrument_head = ihead_q;
        res0.instrument_tail = itail_q;
        res0.side            = side_q;
        res0.client_ref      = client_q;
        res0.tif_code        = tif_q;
        res0.tag_chars       = tag_q;
        res0.firm_id         = data_byte_i;
        cnt                  = 2'd1;
        clear                = 1'b1;
      end else begin
        offset_d = offset_q + 1'b1;
      end
    end

    if (clear) begin
      offset_d = '0;
      price_d  = '0;
      qty_d    = '0;
      ihead_d  = '0;
      itail_d  = '0;
      side_d   = '0;
      client_d = '0;
      tif_d    = '0;
      tag_d    = '0;
      for (int i = 0; i < oebp_pkg::WinLen; i++) begin
        win_d[i] = '0;
      end
      fill_d   = '0;
      fcount_d = '0;
      over_d   = 1'b0;
      // the fixed record is the only end that moves on into the firm string
      firm_d   = !firm_q && !stream_end_i;
    end

    if (cnt == 2'd1) res0.last = 1'b1;
    if (cnt == 2'd2) res1.last = 1'b1;
  end

  assign push_o.count  = cnt;
  assign push_o.first  = res0;
  assign push_o.second = res1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      firm_q   <= 1'b0;
      price_q  <= '0;
      qty_q    <= '0;
      ihead_q  <= '0;
      itail_q  <= '0;
      side_q   <= '0;
      client_q <= '0;
      tif_q    <= '0;
      tag_q    <= '0;
      for (int i = 0; i < oebp_pkg::WinLen; i++) begin
        win_q[i] <= '0;
      end
      fill_q   <= '0;
      fcount_q <= '0;
      over_q   <= 1'b0;
    end else if (accept_i) begin
      offset_q <= offset_d;
      firm_q   <= firm_d;
      price_q  <= price_d;
      qty_q    <= qty_d;
      ihead_q  <= ihead_d;
      itail_q  <= itail_d;
      side_q   <= side_d;
      client_q <= client_d;
      tif_q    <= tif_d;
      tag_q    <= tag_d;
      win_q    <= win_d;
      fill_q   <= fill_d;
      fcount_q <= fcount_d;
      over_q   <= over_d;
    end
  end

endmodule

[src/oebp_out_queue.sv]
// two-entry result queue between the decode and the result channel
module oebp_out_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  oebp_pkg::push_t   push_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output oebp_pkg::result_t head_o,
  output logic [1:0]        count_o
);

  logic [1:0]        cnt_q, cnt_d;
  oebp_pkg::result_t q0_q, q0_d;
  oebp_pkg::result_t q1_q, q1_d;
  logic              pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  // an item may enter only when the queue is empty after this cycle
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign out_valid_o = (cnt_q != 2'd0);
  assign head_o      = q0_q;
  assign count_o     = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    q0_d  = q0_q;
    q1_d  = q1_q;
    if (pop) begin
      if (cnt_q == 2'd2) q0_d = q1_q;
      cnt_d = cnt_q - 2'd1;
    end
    if (accept_i) begin
      q0_d  = push_i.first;
      q1_d  = push_i.second;
      cnt_d = push_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

endmodule

[src/order_entry_body_parser_top.sv]
// top level of the order entry body parser
//
//   channel  dir  contents
//   in_i     in   data_byte, stream_end
//   out_o    out  kind, record fields, firm_byte, last
//
// one byte per cycle while the input is not held; a byte's results sit in the
// two-entry queue the cycle after acceptance. a byte that yields a firm byte and
// the terminator end holds the input while the queue holds both entries.
// reset clears all parse state and empties the queue.
// a stall on the result side holds the input once the queue holds a pending item.
module order_entry_body_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  oebp_in_if.sink     in_i,
  oebp_out_if.source  out_o
);

  oebp_pkg::push_t   push;
  oebp_pkg::result_t head;
  logic              accept;
  logic              in_ready;
  logic [1:0]        q_count;

  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  oebp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (in_i.data_byte),
    .stream_end_i (in_i.stream_end),
    .push_o       (push)
  );

  oebp_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .push_i      (push),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .head_o      (head),
    .count_o     (q_count)
  );

  assign out_o.kind            = head.kind;
  assign out_o.price           = head.price;
  assign out_o.quantity        = head.quantity;
  assign out_o.instrument_head = head.instrument_head;
  assign out_o.instrument_tail = head.instrument_tail;
  assign out_o.side            = head.side;
  assign out_o.client_ref      = head.client_ref;
  assign out_o.tif_code        = head.tif_code;
  assign out_o.tag_chars       = head.tag_chars;
  assign out_o.firm_id         = head.firm_id;
  assign out_o.firm_byte       = head.firm_byte;
  assign out_o.last            = head.last;

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == 2'd2) |-> !in_ready)
    else $error("input taken while queue holds two results");

  a_stream_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.stream_end && (q_count != 2'd2)) |=>
      (out_o.valid && (out_o.kind == oebp_pkg::KindStream) && out_o.last))
    else $error("stream end did not produce a final stream end result");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && ((out_o.kind == oebp_pkg::KindTerm) ||
      (out_o.kind == oebp_pkg::KindStream) || (out_o.kind == oebp_pkg::KindOver)))
      |-> out_o.last)
    else $error("end result not marked last");

  a_record_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind != oebp_pkg::KindRecord)) |->
      ((out_o.price == 64'd0) && (out_o.client_ref == 64'd0) && (out_o.firm_id == 8'd0)))
    else $error("record fields nonzero outside a fixed record");

endmodule
